>>> hdl/mlqs_pkg.sv
//------------------------------------------------------------------------------
// mlqs_pkg
// Shared types and constants of the multilevel queue scheduler.
//------------------------------------------------------------------------------
package mlqs_pkg;

	localparam logic [1:0] ST_RAN  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_DROP = 2'd3;

	localparam logic [1:0] LVL_RR   = 2'd0;
	localparam logic [1:0] LVL_PRIO = 2'd1;
	localparam logic [1:0] LVL_FCFS = 2'd2;

	localparam logic [2:0] REG_QUANTUM = 3'd0;
	localparam logic [2:0] REG_SLICE   = 3'd1;
	localparam logic [2:0] REG_RR_TOP  = 3'd2;
	localparam logic [2:0] REG_PR_TOP  = 3'd3;
	localparam logic [2:0] REG_FC_TOP  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	// result word, first field highest
	typedef struct packed {
		logic [15:0] now_time;
		logic [15:0] wait_time;
		logic [15:0] turnaround;
		logic        finished;
		logic [1:0]  run_level;
		logic [5:0]  run_id;
		logic [1:0]  status;
	} result_t;

endpackage

>>> hdl/multilevel_queue_scheduler_top.sv
//------------------------------------------------------------------------------
// multilevel_queue_scheduler_top
// Three-level queue scheduler: round-robin, priority and first-come levels.
//------------------------------------------------------------------------------
// An arrive word gives its result word in the cycle after it is accepted; a
// tick word gives its result after states S_OUT and S_EXEC (queue head read,
// process read, update and write back). The input takes one arrive word per
// cycle, none in S_OUT or S_EXEC, and stalls while a result waits on m_tready.
// Reset: arst_n clears levels, counters, pending flags and time; queue and
// process RAM contents stay undefined and are only read after being written.
module multilevel_queue_scheduler_top
	import mlqs_pkg::*;
#(
	parameter int MAX_PROCS = 64,
	parameter int TIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // proc_id[5:0], priority_req[9:6], burst_len[19:10]
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // status, run_id, run_level, finished, turnaround,
	                               // wait_time, now_time
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int PW = $clog2(MAX_PROCS);
	localparam int CW = PW + 1;
	localparam int PRW = TIME_BITS + 20;

	logic [3:0] quantum_q, rr_top_q, pr_top_q, fc_top_q;
	logic [7:0] slice_q;

	state_t state_q;
	logic   act_q;

	logic [PW-1:0] head_q [3];
	logic [CW-1:0] cnt_q [3];
	logic [MAX_PROCS-1:0] pend_q;
	logic [1:0] lvl_q;
	logic [7:0] slc_q;
	logic [3:0] qnt_q;
	logic [TIME_BITS-1:0] time_q;

	logic [1:0] sel_lvl_q;
	logic       sel_found_q;

	result_t res_q;
	logic    res_v_q;

	// RAM ports
	logic          q_we [3];
	logic [PW-1:0] q_waddr [3];
	logic [PW-1:0] q_wdata [3];
	logic [PW-1:0] q_raddr [3];
	logic [PW-1:0] q_rdata [3];
	logic           p_we;
	logic [PW-1:0]  p_waddr, p_raddr;
	logic [PRW-1:0] p_wdata, p_rdata;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE) && !(res_v_q && !m_tready);
	assign m_tvalid  = res_v_q;
	assign m_tdata   = {(64 - $bits(result_t))'(0), res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= 4'd4;
			slice_q   <= 8'd10;
			rr_top_q  <= 4'd5;
			pr_top_q  <= 4'd10;
			fc_top_q  <= 4'd15;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_QUANTUM: quantum_q <= cfg_data[3:0];
				REG_SLICE:   slice_q   <= cfg_data;
				REG_RR_TOP:  rr_top_q  <= cfg_data[3:0];
				REG_PR_TOP:  pr_top_q  <= cfg_data[3:0];
				REG_FC_TOP:  fc_top_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// level selection on accept (register state only) and band of an arrive word (from s_tdata)
	logic [1:0] nxt_lvl;
	logic       nxt_found, nxt_switch;
	logic [1:0] band_lvl;
	logic [1:0] cand;
	logic [2:0] cand_sum;
	always_comb begin
		nxt_switch = (cnt_q[lvl_q] == '0) || (slc_q >= slice_q);
		nxt_lvl    = lvl_q;
		nxt_found  = !nxt_switch;
		for (int k = 3; k >= 1; k--) begin
			cand_sum = 3'(lvl_q) + 3'(k);
			cand = (cand_sum >= 3'd3) ? 2'(cand_sum - 3'd3) : 2'(cand_sum);
			if (nxt_switch && cnt_q[cand] != '0) begin
				nxt_lvl   = cand;
				nxt_found = 1'b1;
			end
		end
		band_lvl = 2'd3;
		if (s_tdata[9:6] != 4'd0) begin
			if (s_tdata[9:6] <= rr_top_q) band_lvl = LVL_RR;
			else if (s_tdata[9:6] <= pr_top_q) band_lvl = LVL_PRIO;
			else if (s_tdata[9:6] <= fc_top_q) band_lvl = LVL_FCFS;
		end
	end

	logic [PW-1:0] front_id;
	assign front_id = q_rdata[sel_lvl_q];

	always_comb begin
		p_raddr = (state_q == S_OUT) ? front_id : PW'(s_tdata[5:0]);
		for (int l = 0; l < 3; l++) begin
			q_raddr[l] = head_q[l];
		end
	end

	logic [9:0]  rem_dec;
	logic [TIME_BITS-1:0] tnow, tat;
	logic [15:0] wt;
	assign rem_dec = (p_rdata[9:0] != 10'd0) ? p_rdata[9:0] - 10'd1 : 10'd0;
	assign tnow    = time_q;
	assign tat     = tnow - p_rdata[PRW-1:20];
	assign wt      = 16'(tat - TIME_BITS'(p_rdata[19:10]));

	logic arr_ok;
	assign arr_ok = (band_lvl != 2'd3) && (s_tdata[19:10] != 10'd0) &&
		(int'(s_tdata[5:0]) < MAX_PROCS) && !pend_q[PW'(s_tdata[5:0])];

	logic arr_take, res_load, proc_done, rr_rotate;
	assign arr_take  = (state_q == S_IDLE) && s_tvalid && s_tready && !s_tuser;
	assign res_load  = arr_take || (state_q == S_EXEC);
	assign proc_done = (rem_dec == 10'd0);
	assign rr_rotate = !proc_done && sel_lvl_q == LVL_RR && (qnt_q + 4'd1 >= quantum_q);

	result_t arr_res, exec_res;
	always_comb begin
		arr_res = '0;
		arr_res.run_id    = s_tdata[5:0];
		arr_res.now_time  = 16'(time_q);
		arr_res.status    = arr_ok ? ST_ACC : ST_DROP;
		arr_res.run_level = arr_ok ? band_lvl : '0;
		exec_res = '0;
		exec_res.now_time = 16'(time_q);
		exec_res.status   = ST_IDLE;
		if (sel_found_q) begin
			exec_res.status    = ST_RAN;
			exec_res.run_id    = 6'(front_id);
			exec_res.run_level = sel_lvl_q;
			if (proc_done) begin
				exec_res.finished   = 1'b1;
				exec_res.turnaround = 16'(tat);
				exec_res.wait_time  = wt;
			end
		end
	end

	always_comb begin
		p_we = 1'b0; p_waddr = front_id; p_wdata = {p_rdata[PRW-1:10], rem_dec};
		for (int l = 0; l < 3; l++) begin
			q_we[l] = 1'b0;
			q_waddr[l] = PW'(head_q[l] + PW'(cnt_q[l]));
			q_wdata[l] = PW'(s_tdata[5:0]);
		end
		if (arr_take && arr_ok) begin
			p_we = 1'b1;
			p_waddr = PW'(s_tdata[5:0]);
			p_wdata = {time_q, s_tdata[19:10], s_tdata[19:10]};
			q_we[band_lvl] = 1'b1;
		end else if (state_q == S_EXEC && act_q && sel_found_q) begin
			p_we = 1'b1;
			if (rr_rotate) begin
				q_we[0] = 1'b1;
				q_wdata[0] = front_id;
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_q
		mlqs_ram #(.WIDTH(PW), .DEPTH(MAX_PROCS)) u_q (
			.clk, .we(q_we[l]), .waddr(q_waddr[l]), .wdata(q_wdata[l]),
			.raddr(q_raddr[l]), .rdata(q_rdata[l]));
	end

	mlqs_ram #(.WIDTH(PRW), .DEPTH(MAX_PROCS)) u_proc (
		.clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; res_v_q <= 1'b0; pend_q <= '0;
			lvl_q <= LVL_RR; slc_q <= '0; qnt_q <= '0; time_q <= '0;
			for (int l = 0; l < 3; l++) begin
				head_q[l] <= '0; cnt_q[l] <= '0;
			end
		end else begin
			if (res_load) res_v_q <= 1'b1;
			else if (m_tready) res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						act_q <= s_tuser;
						if (!s_tuser) begin
							res_q <= arr_res;
							if (arr_ok) begin
								pend_q[PW'(s_tdata[5:0])] <= 1'b1;
								cnt_q[band_lvl] <= cnt_q[band_lvl] + CW'(1);
							end
						end else begin
							time_q <= time_q + TIME_BITS'(1);
							sel_found_q <= nxt_found;
							sel_lvl_q <= nxt_lvl;
							if (nxt_switch) begin
								slc_q <= '0; qnt_q <= '0;
							end
							if (nxt_found) lvl_q <= nxt_lvl;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: state_q <= S_EXEC;
				S_EXEC: begin
					res_q <= exec_res;
					if (!sel_found_q) begin
						lvl_q <= LVL_RR;
					end else begin
						slc_q <= slc_q + 8'd1;
						if (proc_done || rr_rotate) qnt_q <= '0;
						else if (sel_lvl_q == LVL_RR) qnt_q <= qnt_q + 4'd1;
						if (proc_done) begin
							pend_q[front_id] <= 1'b0;
							head_q[sel_lvl_q] <= head_q[sel_lvl_q] + PW'(1);
							cnt_q[sel_lvl_q] <= cnt_q[sel_lvl_q] - CW'(1);
						end else if (rr_rotate) begin
							head_q[0] <= head_q[0] + PW'(1);
						end
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("accept while busy");
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> res_v_q) else $error("tick gave no result");
`endif

endmodule

>>> hdl/mlqs_ram.sv
//------------------------------------------------------------------------------
// mlqs_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
module mlqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> bench/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench of the multilevel queue scheduler. A scheduler model
// runs each accepted input word through the three queue levels and keeps the
// expected result words. Every result word is compared field by field with the
// oldest expected one. Register settings change between phases while idle.
//------------------------------------------------------------------------------
module tb_top;
	import mlqs_pkg::*;

	localparam int NPROC = 64;
	localparam int WDOG_LIMIT = 20000;

	class sched_board;
		logic [3:0]  quantum_len;
		logic [7:0]  slice_len;
		logic [3:0]  rr_top;
		logic [3:0]  pr_top;
		logic [3:0]  fc_top;
		logic [5:0]  qmem [3][NPROC];
		int          qhead [3];
		int          qcnt [3];
		logic [9:0]  remain [NPROC];
		logic [9:0]  orig [NPROC];
		logic [15:0] stamp [NPROC];
		bit          pend [NPROC];
		int          cur_lvl;
		int          slice_cnt;
		int          quant_cnt;
		logic [15:0] now;
		result_t     pending_results [$];
		int          errors;

		function new();
			quantum_len = 4;
			slice_len = 10;
			rr_top = 5;
			pr_top = 10;
			fc_top = 15;
			for (int l = 0; l < 3; l++) begin
				qhead[l] = 0;
				qcnt[l] = 0;
			end
			for (int i = 0; i < NPROC; i++)
				pend[i] = 0;
			cur_lvl = 0;
			slice_cnt = 0;
			quant_cnt = 0;
			now = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
				REG_QUANTUM: quantum_len = val[3:0];
				REG_SLICE:   slice_len = val;
				REG_RR_TOP:  rr_top = val[3:0];
				REG_PR_TOP:  pr_top = val[3:0];
				REG_FC_TOP:  fc_top = val[3:0];
				default: ;
			endcase
		endfunction

		function void push(int l, logic [5:0] id);
			if (qcnt[l] < NPROC) begin
				qmem[l][(qhead[l] + qcnt[l]) % NPROC] = id;
				qcnt[l]++;
			end
		endfunction

		function void pop(int l);
			if (qcnt[l] != 0) begin
				qhead[l] = (qhead[l] + 1) % NPROC;
				qcnt[l]--;
			end
		endfunction

		function bit busy();
			return qcnt[0] + qcnt[1] + qcnt[2] != 0;
		endfunction

		function void note_input(bit tick, logic [5:0] id, logic [3:0] prio,
				logic [9:0] burst);
			result_t r;
			int lvl;
			bit found;
			logic [5:0] hid;
			logic [15:0] t;
			r = '0;
			if (!tick) begin
				lvl = 3;
				if (prio >= 1) begin
					if (prio <= rr_top) lvl = 0;
					else if (prio <= pr_top) lvl = 1;
					else if (prio <= fc_top) lvl = 2;
				end
				r.run_id = id;
				if (lvl == 3 || burst == 0 || pend[id]) begin
					r.status = ST_DROP;
				end else begin
					pend[id] = 1;
					remain[id] = burst;
					orig[id] = burst;
					stamp[id] = now;
					push(lvl, id);
					r.status = ST_ACC;
					r.run_level = lvl[1:0];
				end
			end else begin
				found = 1;
				if (qcnt[cur_lvl] == 0 || slice_cnt >= slice_len) begin
					found = 0;
					for (int k = 1; k <= 3 && !found; k++)
						if (qcnt[(cur_lvl + k) % 3] != 0) begin
							cur_lvl = (cur_lvl + k) % 3;
							found = 1;
						end
					slice_cnt = 0;
					quant_cnt = 0;
				end
				now = now + 16'd1;
				if (!found) begin
					r.status = ST_IDLE;
					cur_lvl = 0;
				end else begin
					hid = qmem[cur_lvl][qhead[cur_lvl]];
					r.status = ST_RAN;
					r.run_id = hid;
					r.run_level = cur_lvl[1:0];
					slice_cnt++;
					if (cur_lvl == 0) quant_cnt++;
					if (remain[hid] > 0) remain[hid]--;
					if (remain[hid] == 0) begin
						t = now - stamp[hid];
						r.finished = 1;
						r.turnaround = t;
						r.wait_time = t - 16'(orig[hid]);
						pend[hid] = 0;
						pop(cur_lvl);
						quant_cnt = 0;
					end else if (cur_lvl == 0 && quant_cnt >= quantum_len) begin
						pop(0);
						push(0, hid);
						quant_cnt = 0;
					end
				end
			end
			r.now_time = now;
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (got.status !== exp_r.status)
				$display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
			if (got.run_id !== exp_r.run_id)
				$display("%0t: run_id exp %0d got %0d", $time, exp_r.run_id, got.run_id);
			if (got.run_level !== exp_r.run_level)
				$display("%0t: run_level exp %0d got %0d", $time, exp_r.run_level,
					got.run_level);
			if (got.finished !== exp_r.finished)
				$display("%0t: finished exp %0d got %0d", $time, exp_r.finished,
					got.finished);
			if (got.turnaround !== exp_r.turnaround)
				$display("%0t: turnaround exp %0d got %0d", $time, exp_r.turnaround,
					got.turnaround);
			if (got.wait_time !== exp_r.wait_time)
				$display("%0t: wait_time exp %0d got %0d", $time, exp_r.wait_time,
					got.wait_time);
			if (got.now_time !== exp_r.now_time)
				$display("%0t: now_time exp %0d got %0d", $time, exp_r.now_time,
					got.now_time);
			if (got !== exp_r)
				errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	sched_board board;
	bit          sink_gaps;
	bit          sink_hold;
	int          hold_len;
	int          quiet_cycles;
	bit          timed_out;

	multilevel_queue_scheduler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: check at rising edge, change ready at falling edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(result_t'(m_tdata[$bits(result_t)-1:0]));
	end

	initial begin
		int gap;
		bit held;
		held = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold && !held) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (hold_len) @(negedge clk);
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 10);
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic send_word(bit tick, logic [5:0] id, logic [3:0] prio,
			logic [9:0] burst, bit gaps);
		if (gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= tick;
		s_tdata <= {4'b0, burst, prio, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_input(tick, id, prio, burst);
		@(negedge clk);
	endtask

	task automatic random_phase(int n, bit gaps);
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 30)
				send_word(0, 6'($urandom_range(0, 63)), 4'($urandom_range(1, 15)),
					10'($urandom_range(1, 12)), gaps);
			else if (roll < 34)
				send_word(0, 6'($urandom), 4'($urandom), 10'($urandom), gaps);
			else
				send_word(1, 6'($urandom), 4'($urandom), 10'($urandom), gaps);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sink_gaps = 1;
		sink_hold = 0;
		hold_len = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: drops, bands, extremes, idle tick
		send_word(1, 0, 0, 0, 0);
		send_word(0, 0, 0, 5, 0);
		send_word(0, 1, 3, 0, 0);
		send_word(0, 63, 1, 10'd1023, 0);
		send_word(0, 63, 2, 3, 0);
		send_word(0, 2, 7, 2, 0);
		send_word(0, 3, 15, 3, 0);
		send_word(0, 4, 5, 6, 0);
		for (int i = 0; i < 16; i++)
			send_word(1, 6'h2a, 4'hf, 10'h155, 0);
		s_tvalid <= 1'b0;
		drain();

		// extremes of the registers; smallest quantum, largest slice
		write_reg(REG_QUANTUM, 8'd1);
		write_reg(REG_SLICE, 8'd255);
		write_reg(REG_RR_TOP, 8'd15);
		write_reg(REG_PR_TOP, 8'd1);
		write_reg(REG_FC_TOP, 8'd1);
		random_phase(120, 1);
		drain();

		// zero slice and quantum; sender without gaps, receiver one long hold
		write_reg(REG_QUANTUM, 8'd0);
		write_reg(REG_SLICE, 8'd0);
		write_reg(REG_RR_TOP, 8'd2);
		write_reg(REG_PR_TOP, 8'd8);
		write_reg(REG_FC_TOP, 8'd12);
		hold_len = 60;
		sink_hold = 1;
		random_phase(150, 0);
		drain();

		write_reg(REG_QUANTUM, 8'd15);
		write_reg(REG_SLICE, 8'd1);
		write_reg(REG_RR_TOP, 8'd1);
		write_reg(REG_PR_TOP, 8'd15);
		write_reg(REG_FC_TOP, 8'd15);
		random_phase(150, 1);
		drain();

		write_reg(REG_QUANTUM, 8'd3);
		write_reg(REG_SLICE, 8'd7);
		write_reg(REG_RR_TOP, 8'd9);
		write_reg(REG_PR_TOP, 8'd4);
		write_reg(REG_FC_TOP, 8'd14);
		random_phase(250, 1);
		drain();

		write_reg(REG_QUANTUM, 8'd4);
		write_reg(REG_SLICE, 8'd10);
		write_reg(REG_RR_TOP, 8'd5);
		write_reg(REG_PR_TOP, 8'd10);
		write_reg(REG_FC_TOP, 8'd15);
		random_phase(150, 1);
		sink_gaps = 0;
		random_phase(100, 0);
		drain();
		repeat (20) @(negedge clk);

		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hdl/mlqs_pkg.sv
hdl/mlqs_ram.sv
hdl/multilevel_queue_scheduler_top.sv
bench/tb_top.sv
